// File: rtl/core/mfmd_pkg.sv
package mfmd_pkg;

    localparam int MOTORS_DEFAULT = 8;
    localparam int ID_W           = 11;
    localparam int PAYLOAD_W      = 64;
    localparam int ANGLE_W        = 13;
    localparam int TURN_W         = 19;
    localparam int WORD_W         = 16;
    localparam int TEMP_W         = 8;
    localparam int POS_W          = 32;
    localparam int VEL_W          = 29;
    localparam int MIDX_W         = 3;

    localparam logic [ID_W-1:0] ID_BASE_RESET = 11'd517;

    // fixed-point angle thresholds in encoder counts
    localparam logic [ANGLE_W-1:0]        HALF_TURN  = 13'd4096;
    localparam logic signed [ANGLE_W:0]   JUMP_LIMIT = 14'sd6144;
    localparam logic signed [TURN_W-1:0]  TURN_MAX   = 19'sd262143;
    localparam logic signed [TURN_W-1:0]  TURN_MIN   = -19'sd262144;

    // pi/30 * 2^16, truncated
    localparam int VEL_SCALE = 6862;

    typedef struct packed {
        logic signed [TURN_W-1:0] turn_count;
        logic [ANGLE_W-1:0]       prev_angle;
    } t_entry;

endpackage

// File: rtl/core/mfmd_state_ram.sv
module mfmd_state_ram #(
    parameter int MOTORS = mfmd_pkg::MOTORS_DEFAULT,
    parameter int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output mfmd_pkg::t_entry    o_rd_data,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  mfmd_pkg::t_entry    i_wr_data
);

    mfmd_pkg::t_entry r_mem [MOTORS];
    mfmd_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/mfmd_turn_update.sv
module mfmd_turn_update (
    input  logic [mfmd_pkg::ANGLE_W-1:0] i_raw_angle,
    input  logic                         i_seen,
    input  mfmd_pkg::t_entry             i_entry,
    output mfmd_pkg::t_entry             o_entry
);

    logic [mfmd_pkg::ANGLE_W-1:0]        prev;
    logic signed [mfmd_pkg::TURN_W-1:0]  tc_base;
    logic signed [mfmd_pkg::TURN_W-1:0]  tc_new;
    logic signed [mfmd_pkg::ANGLE_W:0]   diff;

    always_comb begin
        // first frame: seed from the raw angle, jump test then sees zero
        if (i_seen) begin
            prev    = i_entry.prev_angle;
            tc_base = i_entry.turn_count;
        end else begin
            prev    = i_raw_angle;
            tc_base = (i_raw_angle > mfmd_pkg::HALF_TURN) ? -19'sd1 : 19'sd0;
        end

        diff = signed'({1'b0, i_raw_angle}) - signed'({1'b0, prev});

        tc_new = tc_base;
        if (diff > mfmd_pkg::JUMP_LIMIT) begin
            if (tc_base != mfmd_pkg::TURN_MIN) begin
                tc_new = tc_base - 19'sd1;
            end
        end else if (diff < -mfmd_pkg::JUMP_LIMIT) begin
            if (tc_base != mfmd_pkg::TURN_MAX) begin
                tc_new = tc_base + 19'sd1;
            end
        end

        o_entry.turn_count = tc_new;
        o_entry.prev_angle = i_raw_angle;
    end

endmodule

// File: rtl/core/motor_feedback_multiturn_decoder.sv
// Decodes motor feedback frames into a multi-turn position and a fixed-point
// velocity. A frame is a transaction on the slave stream; one whose identifier
// lies in frame_id_base .. frame_id_base + MOTORS - 1 produces one result
// transaction on the master stream, any other frame is taken and dropped. The
// per-motor angle history and turn count live in a small synchronous memory:
// the frame reads its motor's entry on acceptance, stage 1 updates the turn count
// and writes it back, and a one-entry bypass covers a frame for the same motor
// that follows directly. A new frame is accepted every cycle while the output is
// taken every cycle; each frame passes through stage 1 and the output register.
// While a result waits in the output register, stage 1 can still take one more
// frame, after that the input stalls until the result is taken. Write the base
// register only while the block is idle; there is no clearing pass after reset,
// a per-motor seen flag marks entries that are still unwritten.
module motor_feedback_multiturn_decoder #(
    parameter int MOTORS = mfmd_pkg::MOTORS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // configuration: frame identifier base
    input  logic                        i_cfg_wr_en,
    input  logic [mfmd_pkg::ID_W-1:0]   i_cfg_wr_data,

    // frame input
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [79:0]                 s_axis_tdata,  // frame_id[10:0], payload[74:11]

    // decoded output
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // raw_angle[12:0], rotor_rpm[28:13], motor_current[44:29], temperature[52:45],
    // multiturn_position[84:53], velocity_q16[113:85]
    output logic [119:0]                m_axis_tdata,
    output logic [7:0]                  m_axis_tuser   // motor_index[2:0]
);

    localparam int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int DIFF_W = mfmd_pkg::ID_W + 1;

    // ---------------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------------
    logic [mfmd_pkg::ID_W-1:0] r_id_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_base <= mfmd_pkg::ID_BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_id_base <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // input unpack and identifier match
    // ---------------------------------------------------------------------
    logic [mfmd_pkg::ID_W-1:0]      in_id;
    logic [mfmd_pkg::PAYLOAD_W-1:0] in_payload;
    logic [DIFF_W-1:0]              id_diff;
    logic                           id_match;
    logic [IDX_W-1:0]               in_idx;

    assign in_id      = s_axis_tdata[10:0];
    assign in_payload = s_axis_tdata[74:11];

    // full-width window test, the base plus MOTORS may run past 2047
    assign id_diff  = {1'b0, in_id} - {1'b0, r_id_base};
    assign id_match = (in_id >= r_id_base) && (id_diff < DIFF_W'(MOTORS));
    assign in_idx   = id_diff[IDX_W-1:0];

    // ---------------------------------------------------------------------
    // handshake
    // ---------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic s_fire;
    logic s1_fire;

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s1_fire       = r_s1_valid && s1_adv;

    // ---------------------------------------------------------------------
    // stage 1: fields held while the state entry is read
    // ---------------------------------------------------------------------
    logic [IDX_W-1:0]                    r_s1_idx;
    logic [mfmd_pkg::ANGLE_W-1:0]        r_s1_raw;
    logic signed [mfmd_pkg::WORD_W-1:0]  r_s1_rpm;
    logic signed [mfmd_pkg::WORD_W-1:0]  r_s1_cur;
    logic [mfmd_pkg::TEMP_W-1:0]         r_s1_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_fire) begin
            r_s1_valid <= id_match;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && id_match) begin
            r_s1_idx  <= in_idx;
            r_s1_raw  <= in_payload[60:48];
            r_s1_rpm  <= in_payload[47:32];
            r_s1_cur  <= in_payload[31:16];
            r_s1_temp <= in_payload[15:8];
        end
    end

    // ---------------------------------------------------------------------
    // per-motor state: memory, seen flags and write-back bypass
    // ---------------------------------------------------------------------
    mfmd_pkg::t_entry rd_entry;
    mfmd_pkg::t_entry cur_entry;
    mfmd_pkg::t_entry new_entry;
    mfmd_pkg::t_entry r_wb_data;
    logic             r_wb_valid;
    logic [IDX_W-1:0] r_wb_idx;
    logic [MOTORS-1:0] r_seen;

    mfmd_state_ram #(
        .MOTORS (MOTORS),
        .IDX_W  (IDX_W)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_rd_en   (s_fire && id_match),
        .i_rd_addr (in_idx),
        .o_rd_data (rd_entry),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (new_entry)
    );

    // the last write is always the newest copy of its entry, so a hit on it
    // is safe even when it lands well before this read
    assign cur_entry = (r_wb_valid && (r_wb_idx == r_s1_idx)) ? r_wb_data : rd_entry;

    mfmd_turn_update u_turn_update (
        .i_raw_angle (r_s1_raw),
        .i_seen      (r_seen[r_s1_idx]),
        .i_entry     (cur_entry),
        .o_entry     (new_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_wb_valid <= 1'b0;
        end else if (s1_fire) begin
            r_seen[r_s1_idx] <= 1'b1;
            r_wb_valid       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_wb_idx  <= r_s1_idx;
            r_wb_data <= new_entry;
        end
    end

    // ---------------------------------------------------------------------
    // velocity scaling and output register
    // ---------------------------------------------------------------------
    logic signed [mfmd_pkg::VEL_W:0]        vel_full;
    logic [IDX_W+2:0]                       idx_ext;
    logic [mfmd_pkg::MIDX_W-1:0]            r_out_idx;
    logic [mfmd_pkg::ANGLE_W-1:0]           r_out_raw;
    logic [mfmd_pkg::WORD_W-1:0]            r_out_rpm;
    logic [mfmd_pkg::WORD_W-1:0]            r_out_cur;
    logic [mfmd_pkg::TEMP_W-1:0]            r_out_temp;
    logic [mfmd_pkg::POS_W-1:0]             r_out_pos;
    logic [mfmd_pkg::VEL_W-1:0]             r_out_vel;

    assign vel_full = (mfmd_pkg::VEL_W + 1)'(r_s1_rpm)
                    * (mfmd_pkg::VEL_W + 1)'(mfmd_pkg::VEL_SCALE);
    // only the low three bits of the index are reported
    assign idx_ext  = (IDX_W + 3)'(r_s1_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_idx  <= idx_ext[2:0];
            r_out_raw  <= r_s1_raw;
            r_out_rpm  <= r_s1_rpm;
            r_out_cur  <= r_s1_cur;
            r_out_temp <= r_s1_temp;
            // turn count times 8192 plus the raw angle is a plain concatenation
            r_out_pos  <= {new_entry.turn_count, r_s1_raw};
            r_out_vel  <= vel_full[mfmd_pkg::VEL_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_vel, r_out_pos, r_out_temp,
                            r_out_cur, r_out_rpm, r_out_raw};
    assign m_axis_tuser  = {5'd0, r_out_idx};

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_match_to_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_s1_valid == $past(id_match)))
        else $error("stage 1 occupancy does not follow the identifier match");

    a_s1_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("update left no result in the output register");

    a_pos_turns : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_out_pos[31:13] == r_wb_data.turn_count))
        else $error("reported position disagrees with the stored turn count");

    a_seen_set : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_seen[r_wb_idx])
        else $error("written motor entry not marked as seen");

endmodule

// File: tb/motor_feedback_multiturn_decoder_checker.sv
`timescale 1ns / 100ps

module motor_feedback_multiturn_decoder_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [mfmd_pkg::ID_W-1:0]  i_cfg_wr_data,
    input  logic                       i_frame_tvalid,
    input  logic                       i_frame_tready,
    input  logic [79:0]                i_frame_tdata,   // frame_id, payload
    input  logic                       i_decode_tvalid,
    input  logic                       i_decode_tready,
    // raw_angle, rotor_rpm, motor_current, temperature, multiturn_position, velocity_q16
    input  logic [119:0]               i_decode_tdata,
    input  logic [7:0]                 i_decode_tuser,  // motor_index
    output int                         o_pending,
    output int                         o_mismatches
);

    localparam int MOTOR_COUNT     = mfmd_pkg::MOTORS_DEFAULT;
    localparam int HALF_COUNTS     = 4096;
    localparam int JUMP_COUNTS     = 6144;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int TURNS_HI        = 262143;
    localparam int TURNS_LO        = -262144;
    localparam int RAD_Q16_PER_RPM = 6862;

    typedef struct packed {
        logic [mfmd_pkg::MIDX_W-1:0]  motor_index;
        logic [mfmd_pkg::ANGLE_W-1:0] raw_angle;
        logic [mfmd_pkg::WORD_W-1:0]  rotor_rpm;
        logic [mfmd_pkg::WORD_W-1:0]  motor_current;
        logic [mfmd_pkg::TEMP_W-1:0]  temperature;
        logic [mfmd_pkg::POS_W-1:0]   multiturn_position;
        logic [mfmd_pkg::VEL_W-1:0]   velocity_q16;
    } t_decode;

    logic [mfmd_pkg::ID_W-1:0]    id_base;
    bit                           motor_seen [MOTOR_COUNT];
    logic [mfmd_pkg::ANGLE_W-1:0] last_angle [MOTOR_COUNT];
    int                           turns      [MOTOR_COUNT];
    t_decode                      expected_decodes [$];

    // unpacks one frame and advances its motor's turn count
    task automatic decode_frame(input logic [mfmd_pkg::ID_W-1:0] id,
                                input logic [mfmd_pkg::PAYLOAD_W-1:0] p,
                                output bit hit, output t_decode d);
        int                                 motor;
        int                                 jump;
        int                                 count;
        logic [mfmd_pkg::ANGLE_W-1:0]       angle;
        logic signed [mfmd_pkg::WORD_W-1:0] rpm;
        longint                             position;
        longint                             velocity;
        hit = 1'b0;
        d   = '0;
        if (int'(id) < int'(id_base) || int'(id) >= int'(id_base) + MOTOR_COUNT) begin
            return;
        end
        motor = int'(id) - int'(id_base);
        angle = p[60:48];
        rpm   = p[47:32];
        if (!motor_seen[motor]) begin
            last_angle[motor] = angle;
            turns[motor]      = (angle > HALF_COUNTS) ? -1 : 0;
            motor_seen[motor] = 1'b1;
        end
        jump  = int'(angle) - int'(last_angle[motor]);
        count = turns[motor];
        if (jump > JUMP_COUNTS) count = count - 1;
        if (jump < -JUMP_COUNTS) count = count + 1;
        if (count > TURNS_HI) count = TURNS_HI;
        if (count < TURNS_LO) count = TURNS_LO;
        turns[motor]      = count;
        last_angle[motor] = angle;
        position = longint'(angle) + longint'(count) * COUNTS_PER_TURN;
        velocity = longint'(rpm) * RAD_Q16_PER_RPM;
        hit                  = 1'b1;
        d.motor_index        = motor[mfmd_pkg::MIDX_W-1:0];
        d.raw_angle          = angle;
        d.rotor_rpm          = p[47:32];
        d.motor_current      = p[31:16];
        d.temperature        = p[15:8];
        d.multiturn_position = position[mfmd_pkg::POS_W-1:0];
        d.velocity_q16       = velocity[mfmd_pkg::VEL_W-1:0];
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        bit      hit;
        t_decode predicted;
        t_decode oldest;
        if (!i_rst_n) begin
            id_base = mfmd_pkg::ID_BASE_RESET;
            foreach (motor_seen[m]) begin
                motor_seen[m] = 1'b0;
                last_angle[m] = '0;
                turns[m]      = 0;
            end
            expected_decodes.delete();
        end else begin
            if (i_frame_tvalid && i_frame_tready) begin
                decode_frame(i_frame_tdata[10:0], i_frame_tdata[74:11], hit, predicted);
                if (hit) expected_decodes.push_back(predicted);
            end
            if (i_decode_tvalid && i_decode_tready) begin
                if (expected_decodes.size() == 0) begin
                    $error("decoded transaction for motor_index %0d with none pending",
                           i_decode_tuser[2:0]);
                    o_mismatches++;
                end else begin
                    oldest = expected_decodes.pop_front();
                    compare_field("motor_index", oldest.motor_index, i_decode_tuser[2:0]);
                    compare_field("raw_angle", oldest.raw_angle, i_decode_tdata[12:0]);
                    compare_field("rotor_rpm", $signed(oldest.rotor_rpm),
                                  $signed(i_decode_tdata[28:13]));
                    compare_field("motor_current", $signed(oldest.motor_current),
                                  $signed(i_decode_tdata[44:29]));
                    compare_field("temperature", oldest.temperature, i_decode_tdata[52:45]);
                    compare_field("multiturn_position", $signed(oldest.multiturn_position),
                                  $signed(i_decode_tdata[84:53]));
                    compare_field("velocity_q16", $signed(oldest.velocity_q16),
                                  $signed(i_decode_tdata[113:85]));
                end
            end
            if (i_cfg_wr_en) id_base = i_cfg_wr_data;
        end
        o_pending = expected_decodes.size();
    end

endmodule

// File: tb/motor_feedback_multiturn_decoder_test.sv
`timescale 1ns / 100ps

module motor_feedback_multiturn_decoder_test;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_wr_en   = 1'b0;
    logic [mfmd_pkg::ID_W-1:0]   i_cfg_wr_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [79:0]                 s_axis_tdata  = '0;   // frame_id[10:0], payload[74:11]
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // raw_angle[12:0], rotor_rpm[28:13], motor_current[44:29], temperature[52:45],
    // multiturn_position[84:53], velocity_q16[113:85]
    logic [119:0]                m_axis_tdata;
    logic [7:0]                  m_axis_tuser;         // motor_index[2:0]

    int                          pending;
    int                          mismatches;

    // stimulus knobs: per-cycle idle chance in percent on each side
    int                          tx_idle_pct = 0;
    int                          rx_idle_pct = 0;
    bit                          rx_hold     = 1'b0;
    logic [mfmd_pkg::ID_W-1:0]   current_base = mfmd_pkg::ID_BASE_RESET;
    // last angle sent to each motor, so random frames can model a turning rotor
    int                          spin_angle [mfmd_pkg::MOTORS_DEFAULT];

    motor_feedback_multiturn_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    motor_feedback_multiturn_decoder_checker decode_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_frame_tvalid  (s_axis_tvalid),
        .i_frame_tready  (s_axis_tready),
        .i_frame_tdata   (s_axis_tdata),
        .i_decode_tvalid (m_axis_tvalid),
        .i_decode_tready (m_axis_tready),
        .i_decode_tdata  (m_axis_tdata),
        .i_decode_tuser  (m_axis_tuser),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // generous ceiling on the simulation time
    initial begin
        #2_000_000;
        $display("motor_feedback_multiturn_decoder: mismatch");
        $finish;
    end

    // receiver: random back-pressure, or a long hold-off when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                rx_hold = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // bytes 0..1 angle, 2..3 rpm, 4..5 current, 6 temperature, 7 unused
    function automatic logic [mfmd_pkg::PAYLOAD_W-1:0] frame_payload(
        input logic [15:0] angle_word, input logic [15:0] rpm, input logic [15:0] current,
        input logic [7:0] temp, input logic [7:0] spare);
        return {angle_word, rpm, current, temp, spare};
    endfunction

    // one frame transaction; valid stays high into the next frame unless the sender idles
    task automatic offer_frame(input logic [mfmd_pkg::ID_W-1:0] id,
                               input logic [mfmd_pkg::PAYLOAD_W-1:0] payload);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, payload, id};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sender stops until every decode has come out, then lets the pipeline empty
    task automatic settle_decoder();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_id_base(input logic [mfmd_pkg::ID_W-1:0] base);
        settle_decoder();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= base;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        current_base  = base;
    endtask

    // mostly frames inside the motor window, the rest edge identifiers and noise
    task automatic offer_random_frame();
        int                                kind;
        int                                motor;
        int                                next_angle;
        logic [mfmd_pkg::ID_W-1:0]         id;
        logic [15:0]                       angle_word;
        logic [mfmd_pkg::PAYLOAD_W-1:0]    payload;
        kind  = $urandom_range(99);
        motor = $urandom_range((current_base > 11'd2040) ? 2047 - current_base : 7);
        if (kind < 80) begin
            id = mfmd_pkg::ID_W'(current_base + motor);
        end else if (kind < 88) begin
            id = kind[0] ? mfmd_pkg::ID_W'(current_base - 1)
                         : mfmd_pkg::ID_W'(current_base + mfmd_pkg::MOTORS_DEFAULT);
        end else begin
            id = mfmd_pkg::ID_W'($urandom_range(2047));
        end
        if ($urandom_range(1)) begin
            angle_word = 16'($urandom_range(16'hFFFF));
        end else begin
            // rotor turning by up to +-3000 counts, wrapping round the turn
            next_angle = spin_angle[motor] + $urandom_range(6000) - 3000;
            angle_word = {3'($urandom_range(7)), next_angle[12:0]};
        end
        if (kind < 80) spin_angle[motor] = angle_word[12:0];
        payload = {$urandom(), $urandom()};
        payload[63:48] = angle_word;
        offer_frame(id, payload);
    endtask

    task automatic offer_random_frames(input int count, input int hold_at, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) rx_hold = 1'b1;
            if (i == pause_at) settle_decoder();
            offer_random_frame();
        end
    endtask

    initial begin : stimulus
        logic [mfmd_pkg::ID_W-1:0] turn_id;
        // light sender idling, heavy receiver stalls
        tx_idle_pct = 10;
        rx_idle_pct = 75;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identifiers just outside the window and at the ends of the range: no decode
        offer_frame(mfmd_pkg::ID_BASE_RESET - 11'd1, {$urandom(), $urandom()});
        offer_frame(mfmd_pkg::ID_BASE_RESET + mfmd_pkg::ID_W'(mfmd_pkg::MOTORS_DEFAULT),
                    {$urandom(), $urandom()});
        offer_frame(11'd0, {$urandom(), $urandom()});
        offer_frame(11'd2047, {$urandom(), $urandom()});

        // first frames: angle field wider than 13 bits, exactly half a turn, just above
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd0,
                    frame_payload(16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd1,
                    frame_payload(16'h1000, 16'h8000, 16'h7FFF, 8'h00, 8'h00));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd2,
                    frame_payload(16'h1001, 16'h0000, 16'hFFFF, 8'h80, 8'h5A));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd7,
                    frame_payload(16'h0000, 16'hFFFF, 16'h0000, 8'h01, 8'hA5));

        // back-to-back frames for one motor across the wrap, both directions
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd0,
                    frame_payload(16'hE000, 16'h0001, 16'h0001, 8'h10, 8'h00));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd0,
                    frame_payload(16'h1FFF, 16'hFFFF, 16'hFFFF, 8'h20, 8'hFF));

        // jump limit: exactly 6144 either way counts nothing, 6145 does
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd7,
                    frame_payload(16'd6144, 16'd100, 16'd0, 8'h30, 8'h00));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd7,
                    frame_payload(16'd0, 16'd200, 16'd0, 8'h31, 8'h00));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd7,
                    frame_payload(16'd6145, 16'd300, 16'd0, 8'h32, 8'h00));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd7,
                    frame_payload(16'd0, 16'd400, 16'd0, 8'h33, 8'h00));

        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd1,
                    frame_payload(16'h0000, 16'd5, 16'd5, 8'h40, 8'h00));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd1,
                    frame_payload(16'h1FFF, 16'd6, 16'd6, 8'h41, 8'h00));
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd3, {$urandom(), $urandom()});
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd5, {$urandom(), $urandom()});
        offer_frame(mfmd_pkg::ID_BASE_RESET + 11'd6, {$urandom(), $urandom()});

        // forward spin on motor 4 over a run of turns, then a few turns back
        turn_id = mfmd_pkg::ID_BASE_RESET + 11'd4;
        repeat (20) begin
            offer_frame(turn_id, frame_payload(16'd0, 16'($urandom_range(16'hFFFF)),
                                               16'($urandom_range(16'hFFFF)), 8'h50, 8'h00));
            offer_frame(turn_id, frame_payload(16'd3100, 16'($urandom_range(16'hFFFF)),
                                               16'($urandom_range(16'hFFFF)), 8'h51, 8'h00));
            offer_frame(turn_id, frame_payload(16'd6200, 16'($urandom_range(16'hFFFF)),
                                               16'($urandom_range(16'hFFFF)), 8'h52, 8'h00));
        end
        repeat (3) begin
            offer_frame(turn_id, frame_payload(16'd0, 16'd1, 16'd1, 8'h60, 8'h00));
            offer_frame(turn_id, frame_payload(16'd6200, 16'd2, 16'd2, 8'h61, 8'h00));
            offer_frame(turn_id, frame_payload(16'd3100, 16'd3, 16'd3, 8'h62, 8'h00));
        end

        // lowest base, light sender idling, heavy receiver stalls and one long hold-off
        write_id_base(11'd0);
        offer_random_frames(250, 120, -1);

        // highest base leaves a single motor in range; then a window ending at 2047
        tx_idle_pct = 75;
        rx_idle_pct = 10;
        write_id_base(11'd2047);
        offer_random_frames(100, -1, -1);
        write_id_base(11'd2040);
        offer_random_frames(150, -1, 75);

        // full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_id_base(mfmd_pkg::ID_W'($urandom_range(2047)));
        offer_random_frames(150, -1, -1);
        write_id_base(mfmd_pkg::ID_BASE_RESET);
        offer_random_frames(100, -1, -1);

        settle_decoder();
        if (mismatches == 0) begin
            $display("motor_feedback_multiturn_decoder: match");
        end else begin
            $display("motor_feedback_multiturn_decoder: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/mfmd_pkg.sv
rtl/core/mfmd_state_ram.sv
rtl/core/mfmd_turn_update.sv
rtl/core/motor_feedback_multiturn_decoder.sv
tb/motor_feedback_multiturn_decoder_checker.sv
tb/motor_feedback_multiturn_decoder_test.sv
